>>> hw/rtl/bcmc_pkg.sv
package bcmc_pkg;

  localparam int unsigned CellInputs     = 4;
  localparam int unsigned CellIdxW       = $clog2(CellInputs);
  localparam int unsigned DefCellCount   = 4;
  localparam int unsigned MvW            = 16;
  localparam int unsigned MaW            = 13;
  localparam int unsigned CountW         = 4;
  localparam int unsigned BypassW        = 4;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 16;
  // Wide enough for 3 * high and for cell_full + 2 * low.
  localparam int unsigned CmpW           = MvW + 2;

  localparam logic [CfgIdxW-1:0] RegCellFull      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPackCharge    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFullCurrent   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBalanceCurent = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAdapterLimit  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGoodLimit     = 3'd5;

  localparam logic [1:0] ModeNone      = 2'd0;
  localparam logic [1:0] ModeCharged   = 2'd1;
  localparam logic [1:0] ModeBalancing = 2'd2;
  localparam logic [1:0] ModeCharging  = 2'd3;

  typedef struct packed {
    logic [MvW-1:0]    cell_full_mv;
    logic [MvW-1:0]    pack_charge_mv;
    logic [MaW-1:0]    full_current_ma;
    logic [MaW-1:0]    balance_current_ma;
    logic [MaW-1:0]    adapter_limit_ma;
    logic [CountW-1:0] good_count_limit;
  } cfg_t;

  typedef struct packed {
    logic                            battery_good;
    logic                            adapter_present;
    logic                            boot_success;
    logic [CellInputs-1:0][MvW-1:0]  cells;
  } item_t;

  typedef struct packed {
    logic [MvW-1:0]      v_high;
    logic [MvW-1:0]      v_low;
    logic [CellIdxW-1:0] i_high;
  } scan_t;

  typedef struct packed {
    logic               robot_power;
    logic [1:0]         mode;
    logic               charge_inhibit;
    logic [MvW-1:0]     charge_voltage_mv;
    logic [MaW-1:0]     charge_current_ma;
    logic [MaW-1:0]     adapter_current_ma;
    logic [BypassW-1:0] bypass_cell;
    logic               booted;
  } res_t;

endpackage

>>> hw/rtl/bcmc_cfg_regs.sv
module bcmc_cfg_regs import bcmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_full_mv       <= MvW'(4200);
      cfg_q.pack_charge_mv     <= MvW'(16800);
      cfg_q.full_current_ma    <= MaW'(2000);
      cfg_q.balance_current_ma <= MaW'(200);
      cfg_q.adapter_limit_ma   <= MaW'(3000);
      cfg_q.good_count_limit   <= CountW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCellFull:      cfg_q.cell_full_mv       <= cfg_wdata_i[MvW-1:0];
        RegPackCharge:    cfg_q.pack_charge_mv     <= cfg_wdata_i[MvW-1:0];
        RegFullCurrent:   cfg_q.full_current_ma    <= cfg_wdata_i[MaW-1:0];
        RegBalanceCurent: cfg_q.balance_current_ma <= cfg_wdata_i[MaW-1:0];
        RegAdapterLimit:  cfg_q.adapter_limit_ma   <= cfg_wdata_i[MaW-1:0];
        RegGoodLimit:     cfg_q.good_count_limit   <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/bcmc_cell_scan.sv
module bcmc_cell_scan import bcmc_pkg::*; #(
  parameter int unsigned CELL_COUNT = DefCellCount
) (
  input  logic [CellInputs-1:0][MvW-1:0] cells_i,
  output scan_t                          scan_o
);

  // Only the first cells are scanned; the count is clamped to the inputs present.
  localparam int unsigned ScanN = (CELL_COUNT > CellInputs) ? CellInputs :
                                  ((CELL_COUNT < 1) ? 1 : CELL_COUNT);

  always_comb begin
    scan_o.v_high = cells_i[0];
    scan_o.v_low  = cells_i[0];
    scan_o.i_high = '0;
    for (int i = 1; i < CellInputs; i++) begin
      if (i < ScanN) begin
        // Strict compares keep the first index on ties.
        if (cells_i[i] > scan_o.v_high) begin
          scan_o.v_high = cells_i[i];
          scan_o.i_high = CellIdxW'(i);
        end
        if (cells_i[i] < scan_o.v_low) begin
          scan_o.v_low = cells_i[i];
        end
      end
    end
  end

endmodule

>>> hw/rtl/bcmc_mode_ctrl.sv
module bcmc_mode_ctrl import bcmc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  item_t item_i,
  input  scan_t scan_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  logic [CountW-1:0] good_count_q, good_count_d;
  logic              charger_ready_q, charger_ready_d;
  logic              charged_q, charged_d;
  logic              balancing_q, balancing_d;
  logic              charging_q, charging_d;
  logic [CountW-1:0] limit;
  logic              power;
  logic [CmpW-1:0]   high_x3;
  logic [CmpW-1:0]   thresh;

  assign limit   = (cfg_i.good_count_limit == '0) ? CountW'(1) : cfg_i.good_count_limit;
  assign high_x3 = CmpW'({scan_i.v_high, 1'b0}) + CmpW'(scan_i.v_high);
  assign thresh  = CmpW'(cfg_i.cell_full_mv) + CmpW'({scan_i.v_low, 1'b0});

  always_comb begin
    good_count_d    = '0;
    charger_ready_d = charger_ready_q;
    charged_d       = charged_q;
    balancing_d     = balancing_q;
    charging_d      = charging_q;
    res_o           = '0;

    if (item_i.battery_good) begin
      good_count_d = (good_count_q < limit) ? good_count_q + CountW'(1) : limit;
    end
    power = (good_count_d == limit);

    if (item_i.adapter_present && power) begin
      if (item_i.boot_success) begin
        charger_ready_d = 1'b1;
      end
      if (charger_ready_d) begin
        res_o.adapter_current_ma = cfg_i.adapter_limit_ma;
        if (scan_i.v_high >= cfg_i.cell_full_mv || charged_q) begin
          charged_d            = 1'b1;
          charging_d           = 1'b0;
          balancing_d          = 1'b0;
          res_o.mode           = ModeCharged;
          res_o.charge_inhibit = 1'b1;
        end else if (high_x3 >= thresh || balancing_q) begin
          charged_d               = 1'b0;
          charging_d              = 1'b1;
          balancing_d             = 1'b1;
          res_o.mode              = ModeBalancing;
          res_o.charge_voltage_mv = cfg_i.pack_charge_mv;
          res_o.charge_current_ma = cfg_i.balance_current_ma;
          res_o.bypass_cell       = BypassW'(scan_i.i_high) + BypassW'(1);
        end else begin
          charged_d               = 1'b0;
          charging_d              = 1'b1;
          balancing_d             = 1'b0;
          res_o.mode              = ModeCharging;
          res_o.charge_voltage_mv = cfg_i.pack_charge_mv;
          res_o.charge_current_ma = cfg_i.full_current_ma;
        end
      end
    end

    res_o.robot_power = power;
    res_o.booted      = charger_ready_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_count_q    <= '0;
      charger_ready_q <= 1'b0;
      charged_q       <= 1'b0;
      balancing_q     <= 1'b0;
      charging_q      <= 1'b0;
    end else if (advance_i) begin
      good_count_q    <= good_count_d;
      charger_ready_q <= charger_ready_d;
      charged_q       <= charged_d;
      balancing_q     <= balancing_d;
      charging_q      <= charging_d;
    end
  end

endmodule

>>> hw/rtl/battery_charge_mode_control_core.sv
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    battery_good_i, adapter_present_i, boot_success_i,
//                                      cell0_mv_i .. cell3_mv_i
// out       out_valid_o / out_ready_i  robot_power_o, mode_o, charge_inhibit_o,
//                                      charge_voltage_mv_o, charge_current_ma_o,
//                                      adapter_current_ma_o, bypass_cell_o, booted_o
// cfg       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while out_ready_i stays high.
// An accepted item sits in the input register, is evaluated in one pass of cell scan
// and mode logic, and moves to the result register together with the state update.
// The input register refills in the same cycle that it drains, so a stalled output
// only backs up the input once both registers hold an item.
// Reset clears the state, the register valid bits and restores the configuration defaults.
module battery_charge_mode_control_core import bcmc_pkg::*; #(
  parameter int unsigned CELL_COUNT = DefCellCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                battery_good_i,
  input  logic                adapter_present_i,
  input  logic                boot_success_i,
  input  logic [MvW-1:0]      cell0_mv_i,
  input  logic [MvW-1:0]      cell1_mv_i,
  input  logic [MvW-1:0]      cell2_mv_i,
  input  logic [MvW-1:0]      cell3_mv_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                robot_power_o,
  output logic [1:0]          mode_o,
  output logic                charge_inhibit_o,
  output logic [MvW-1:0]      charge_voltage_mv_o,
  output logic [MaW-1:0]      charge_current_ma_o,
  output logic [MaW-1:0]      adapter_current_ma_o,
  output logic [BypassW-1:0]  bypass_cell_o,
  output logic                booted_o
);

  cfg_t  cfg;
  item_t item_q;
  logic  item_valid_q;
  scan_t scan;
  res_t  res;
  res_t  res_q;
  logic  res_valid_q;
  logic  advance;

  bcmc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held item is evaluated when the result register is free or being drained.
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.battery_good    <= battery_good_i;
      item_q.adapter_present <= adapter_present_i;
      item_q.boot_success    <= boot_success_i;
      item_q.cells           <= {cell3_mv_i, cell2_mv_i, cell1_mv_i, cell0_mv_i};
    end
  end

  bcmc_cell_scan #(
    .CELL_COUNT (CELL_COUNT)
  ) u_cell_scan (
    .cells_i (item_q.cells),
    .scan_o  (scan)
  );

  bcmc_mode_ctrl u_mode_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .scan_i    (scan),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = res_valid_q;
  assign robot_power_o        = res_q.robot_power;
  assign mode_o               = res_q.mode;
  assign charge_inhibit_o     = res_q.charge_inhibit;
  assign charge_voltage_mv_o  = res_q.charge_voltage_mv;
  assign charge_current_ma_o  = res_q.charge_current_ma;
  assign adapter_current_ma_o = res_q.adapter_current_ma;
  assign bypass_cell_o        = res_q.bypass_cell;
  assign booted_o             = res_q.booted;

endmodule

>>> verif/battery_charge_mode_control_core_test.sv
`timescale 1ns / 100ps

module battery_charge_mode_control_core_test;
  import bcmc_pkg::*;

  localparam int unsigned CellScan    = DefCellCount;
  localparam int          HoldCycles  = 64;
  localparam int          StallLimit  = 1000;
  localparam int          DrainCycles = 6;

  // Predicts the charger setpoints from the status updates and checks each result.
  class charge_mode_board;
    logic [MvW-1:0]    full_mv;
    logic [MvW-1:0]    pack_mv;
    logic [MaW-1:0]    fast_ma;
    logic [MaW-1:0]    bal_ma;
    logic [MaW-1:0]    adapt_ma;
    logic [CountW-1:0] good_lim;
    logic [CountW-1:0] good_cnt;
    bit                booted_st;
    bit                charged_st;
    bit                balancing_st;
    res_t              due_q[$];
    int                failures;

    function new();
      full_mv      = 16'd4200;
      pack_mv      = 16'd16800;
      fast_ma      = 13'd2000;
      bal_ma       = 13'd200;
      adapt_ma     = 13'd3000;
      good_lim     = 4'd10;
      good_cnt     = '0;
      booted_st    = 1'b0;
      charged_st   = 1'b0;
      balancing_st = 1'b0;
      failures     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegCellFull:      full_mv  = data[MvW-1:0];
        RegPackCharge:    pack_mv  = data[MvW-1:0];
        RegFullCurrent:   fast_ma  = data[MaW-1:0];
        RegBalanceCurent: bal_ma   = data[MaW-1:0];
        RegAdapterLimit:  adapt_ma = data[MaW-1:0];
        RegGoodLimit:     good_lim = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function void note_update(item_t u);
      logic [CountW-1:0] lim;
      int   hi, lo, ih, n;
      res_t r;
      lim = (good_lim == '0) ? CountW'(1) : good_lim;
      if (u.battery_good) begin
        good_cnt = (good_cnt < lim) ? good_cnt + CountW'(1) : lim;
      end else begin
        good_cnt = '0;
      end
      r = '0;
      r.robot_power = (good_cnt == lim);
      if (u.adapter_present && r.robot_power) begin
        if (!booted_st && u.boot_success) begin
          booted_st = 1'b1;
        end
        if (booted_st) begin
          n = CellScan;
          if (n > CellInputs) n = CellInputs;
          if (n < 1) n = 1;
          hi = int'(u.cells[0]);
          lo = int'(u.cells[0]);
          ih = 0;
          for (int i = 1; i < n; i++) begin
            if (int'(u.cells[i]) > hi) begin
              hi = int'(u.cells[i]);
              ih = i;
            end
            if (int'(u.cells[i]) < lo) lo = int'(u.cells[i]);
          end
          r.adapter_current_ma = adapt_ma;
          if (hi >= int'(full_mv) || charged_st) begin
            charged_st   = 1'b1;
            balancing_st = 1'b0;
            r.mode           = ModeCharged;
            r.charge_inhibit = 1'b1;
          end else if (3 * hi - 2 * lo >= int'(full_mv) || balancing_st) begin
            balancing_st = 1'b1;
            r.mode              = ModeBalancing;
            r.charge_voltage_mv = pack_mv;
            r.charge_current_ma = bal_ma;
            r.bypass_cell       = BypassW'(ih + 1);
          end else begin
            r.mode              = ModeCharging;
            r.charge_voltage_mv = pack_mv;
            r.charge_current_ma = fast_ma;
          end
        end
      end
      r.booted = booted_st;
      due_q.push_back(r);
    endfunction

    function void cmp(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_q.size() == 0) begin
        $display("%0t: result arrived with no item pending", $time);
        failures++;
        return;
      end
      want = due_q.pop_front();
      cmp("robot_power", 32'(want.robot_power), 32'(got.robot_power));
      cmp("mode", 32'(want.mode), 32'(got.mode));
      cmp("charge_inhibit", 32'(want.charge_inhibit), 32'(got.charge_inhibit));
      cmp("charge_voltage_mv", 32'(want.charge_voltage_mv), 32'(got.charge_voltage_mv));
      cmp("charge_current_ma", 32'(want.charge_current_ma), 32'(got.charge_current_ma));
      cmp("adapter_current_ma", 32'(want.adapter_current_ma),
          32'(got.adapter_current_ma));
      cmp("bypass_cell", 32'(want.bypass_cell), 32'(got.bypass_cell));
      cmp("booted", 32'(want.booted), 32'(got.booted));
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                battery_good_i = 1'b0;
  logic                adapter_present_i = 1'b0;
  logic                boot_success_i = 1'b0;
  logic [MvW-1:0]      cell0_mv_i = '0;
  logic [MvW-1:0]      cell1_mv_i = '0;
  logic [MvW-1:0]      cell2_mv_i = '0;
  logic [MvW-1:0]      cell3_mv_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                robot_power_o;
  logic [1:0]          mode_o;
  logic                charge_inhibit_o;
  logic [MvW-1:0]      charge_voltage_mv_o;
  logic [MaW-1:0]      charge_current_ma_o;
  logic [MaW-1:0]      adapter_current_ma_o;
  logic [BypassW-1:0]  bypass_cell_o;
  logic                booted_o;

  charge_mode_board board;
  bit               no_idle = 1'b0;
  bit               hold_req = 1'b0;
  int               idle_cycles = 0;

  battery_charge_mode_control_core #(
    .CELL_COUNT(CellScan)
  ) DUT (.*);

  always #2 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  function automatic item_t status_of(bit good, bit adapter, bit boot, logic [MvW-1:0] c0,
                                      logic [MvW-1:0] c1, logic [MvW-1:0] c2,
                                      logic [MvW-1:0] c3);
    item_t u;
    u.battery_good    = good;
    u.adapter_present = adapter;
    u.boot_success    = boot;
    u.cells[0]        = c0;
    u.cells[1]        = c1;
    u.cells[2]        = c2;
    u.cells[3]        = c3;
    return u;
  endfunction

  function automatic item_t random_status(int good_pct, int adapt_pct, int cell_max);
    item_t u;
    u.battery_good    = ($urandom_range(99) < good_pct);
    u.adapter_present = ($urandom_range(99) < adapt_pct);
    u.boot_success    = 1'($urandom_range(1));
    for (int i = 0; i < CellInputs; i++) begin
      u.cells[i] = MvW'($urandom_range(cell_max, 0));
    end
    // Copying one cell onto another makes ties that exercise the first-index rule.
    if ($urandom_range(3) == 0) begin
      u.cells[$urandom_range(CellInputs - 1)] = u.cells[$urandom_range(CellInputs - 1)];
    end
    return u;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_update(item_t u);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    battery_good_i    <= u.battery_good;
    adapter_present_i <= u.adapter_present;
    boot_success_i    <= u.boot_success;
    cell0_mv_i        <= u.cells[0];
    cell1_mv_i        <= u.cells[1];
    cell2_mv_i        <= u.cells[2];
    cell3_mv_i        <= u.cells[3];
    do @(posedge clk_i); while (!in_ready_o);
    board.note_update(u);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    board.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Registers change only once every pending result has come out.
  task automatic reconfigure(logic [MvW-1:0] full, logic [MvW-1:0] pack, logic [MaW-1:0] fast,
                             logic [MaW-1:0] bal, logic [MaW-1:0] adapt,
                             logic [CountW-1:0] lim);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    write_reg(RegCellFull, CfgDataW'(full));
    write_reg(RegPackCharge, CfgDataW'(pack));
    write_reg(RegFullCurrent, CfgDataW'(fast));
    write_reg(RegBalanceCurent, CfgDataW'(bal));
    write_reg(RegAdapterLimit, CfgDataW'(adapt));
    write_reg(RegGoodLimit, CfgDataW'(lim));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_updates(int count, int good_pct, int adapt_pct, int cell_max, bit squeeze);
    for (int k = 0; k < count; k++) begin
      if (squeeze && k == 20) begin
        hold_req = 1'b1;
        no_idle  = 1'b1;
      end else if (k % 25 == 0 && !hold_req) begin
        no_idle = ($urandom_range(3) == 0);
      end
      send_update(random_status(good_pct, adapt_pct, cell_max));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: a bad item with all cells at full scale, then three good ones.
    send_update(status_of(1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    repeat (3) send_update(status_of(1'b1, 1'b1, 1'b0, 16'd1000, 16'd1000, 16'd1000, 16'd1000));
    // The limit drops below the running count, so the next good item saturates to it.
    reconfigure(16'd4200, 16'd16800, 13'd2000, 13'd200, 13'd3000, 4'd2);
    send_update(status_of(1'b1, 1'b1, 1'b0, 16'd1000, 16'd1000, 16'd1000, 16'd1000));
    // A successful boot is ignored without the adapter.
    send_update(status_of(1'b1, 1'b0, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000));
    send_update(status_of(1'b1, 1'b1, 1'b1, 16'd1300, 16'd1390, 16'd1390, 16'd1200));
    send_update(status_of(1'b0, 1'b1, 1'b1, 16'd1300, 16'd1300, 16'd1300, 16'd1300));
    // A zero limit behaves as a limit of one.
    reconfigure(16'd4200, 16'd16800, 13'd2000, 13'd200, 13'd3000, 4'd0);
    send_update(status_of(1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    send_update(status_of(1'b1, 1'b1, 1'b1, 16'd1399, 16'd0, 16'd1399, 16'd700));

    // Fast charging: the cells stay low enough that balancing never starts.
    reconfigure(16'hFFFF, 16'd14000, 13'd1500, 13'd300, 13'd2500, 4'd3);
    run_updates(90, 90, 85, 21000, 1'b0);
    reconfigure(16'd4200, 16'hFFFF, 13'h1FFF, 13'd0, 13'h1FFF, 4'd15);
    run_updates(90, 97, 90, 1399, 1'b0);

    // Balancing is entered with the highest cell tied on the last two inputs.
    reconfigure(16'hFFFF, 16'd0, 13'h1FFF, 13'h1FFF, 13'd0, 4'd1);
    send_update(status_of(1'b1, 1'b1, 1'b0, 16'd10000, 16'd20000, 16'd65000, 16'd65000));
    send_update(status_of(1'b1, 1'b1, 1'b1, 16'd500, 16'd500, 16'd500, 16'd500));
    run_updates(90, 90, 85, 65534, 1'b1);
    reconfigure(16'd40000, 16'd12345, 13'd4096, 13'd0, 13'd4095, 4'd4);
    run_updates(90, 92, 85, 39999, 1'b0);
    reconfigure(16'hFFFF, 16'h5555, 13'h0AAA, 13'h1555, 13'h1FFF, 4'd15);
    run_updates(90, 97, 90, 65534, 1'b0);

    // The highest cell reaches the threshold exactly; charged mode then stays.
    reconfigure(16'd3000, 16'hFFFF, 13'd2000, 13'd200, 13'd3000, 4'd1);
    send_update(status_of(1'b1, 1'b1, 1'b0, 16'd2999, 16'd3000, 16'd100, 16'd3000));
    send_update(status_of(1'b1, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    run_updates(45, 90, 85, 65535, 1'b0);
    reconfigure(16'd0, 16'hAAAA, 13'h1FFF, 13'h1FFF, 13'd1234, 4'd2);
    run_updates(45, 90, 85, 65535, 1'b0);

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int   stall_left;
    res_t got;
    stall_left = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.robot_power        = robot_power_o;
        got.mode               = mode_o;
        got.charge_inhibit     = charge_inhibit_o;
        got.charge_voltage_mv  = charge_voltage_mv_o;
        got.charge_current_ma  = charge_current_ma_o;
        got.adapter_current_ma = adapter_current_ma_o;
        got.bypass_cell        = bypass_cell_o;
        got.booted             = booted_o;
        board.check_result(got);
      end
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StallLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

>>> files.f
hw/rtl/bcmc_pkg.sv
hw/rtl/bcmc_cfg_regs.sv
hw/rtl/bcmc_cell_scan.sv
hw/rtl/bcmc_mode_ctrl.sv
hw/rtl/battery_charge_mode_control_core.sv
verif/battery_charge_mode_control_core_test.sv
